>>> design/ktsr_pkg.sv
// ----------------------------------------------------------------------------
// ktsr_pkg
// Shared types and codes for the key table with swap remove.
// ----------------------------------------------------------------------------
package ktsr_pkg;

  // Default table depth
  localparam int DEPTH_DEF = 64;

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TOTAL_W-1:0]  total_t;

  // Operation codes
  localparam func_t FN_ADD    = 3'd0;
  localparam func_t FN_ADD_UQ = 3'd1;
  localparam func_t FN_FIND   = 3'd2;
  localparam func_t FN_REMOVE = 3'd3;
  localparam func_t FN_READ   = 3'd4;
  localparam func_t FN_CLEAR  = 3'd5;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_RANGE     = 2'd3;

  // Ring control from the sequencer to the cell row
  typedef struct packed {
    logic shift;     // rotate the ring by one cell
    key_t tail_key;  // value entering the tail cell
  } ring_ctl_t;

endpackage

>>> design/ktsr_req_if.sv
// ----------------------------------------------------------------------------
// ktsr_req_if
// Request channel: operation, key and position with valid/ready.
// ----------------------------------------------------------------------------
interface ktsr_req_if;
  logic            valid;
  logic            ready;
  ktsr_pkg::func_t func;
  ktsr_pkg::key_t  key;
  ktsr_pkg::pos_t  position;

  modport source (output valid, output func, output key, output position, input ready);
  modport sink   (input valid, input func, input key, input position, output ready);
endinterface

>>> design/ktsr_rsp_if.sv
// ----------------------------------------------------------------------------
// ktsr_rsp_if
// Response channel: status, position, key read and entry total.
// ----------------------------------------------------------------------------
interface ktsr_rsp_if;
  logic              valid;
  logic              ready;
  ktsr_pkg::status_t status;
  ktsr_pkg::pos_t    found_position;
  ktsr_pkg::key_t    read_key;
  ktsr_pkg::total_t  entry_total;

  modport source (output valid, output status, output found_position, output read_key,
                  output entry_total, input ready);
  modport sink   (input valid, input status, input found_position, input read_key,
                  input entry_total, output ready);
endinterface

>>> design/ktsr_cell.sv
// ----------------------------------------------------------------------------
// ktsr_cell
// One ring cell: holds a key and takes its neighbor's key on each shift.
// ----------------------------------------------------------------------------
module ktsr_cell (
  input  logic           clk,
  input  logic           shift,
  input  ktsr_pkg::key_t from_next,
  output ktsr_pkg::key_t key
);

  // Key register, loaded from the next cell while the ring rotates
  always_ff @(posedge clk) begin
    if (shift) begin
      key <= from_next;
    end
  end

endmodule

>>> design/ktsr_seq.sv
// ----------------------------------------------------------------------------
// ktsr_seq
// Sequencer: rotates the cell ring once per operation, watches the head cell,
// splices added or moved keys in at the tail, and forms the response.
// ----------------------------------------------------------------------------
module ktsr_seq #(
  parameter int DEPTH = ktsr_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  ktsr_req_if.sink            req,
  ktsr_rsp_if.source          rsp,
  input  ktsr_pkg::key_t      head_key,
  output ktsr_pkg::ring_ctl_t ring
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring step / entry index
  localparam int CW = $clog2(DEPTH + 1);                 // entry count
  localparam int XW = CW + 1;                            // count arithmetic headroom
  localparam int PW = (XW > ktsr_pkg::POS_W) ? XW : ktsr_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [IW-1:0]     step;
  logic [CW-1:0]     count;
  logic              found;
  logic [IW-1:0]     at;
  ktsr_pkg::func_t   op_func;
  ktsr_pkg::key_t    op_key;
  ktsr_pkg::pos_t    op_pos;
  ktsr_pkg::key_t    last_key;   // key at position count-1
  ktsr_pkg::key_t    last_cand;  // key that becomes last after a remove
  ktsr_pkg::key_t    rd_key;

  logic              in_range;
  logic              first;
  logic              found_fin;
  logic [IW-1:0]     at_fin;
  logic              has_room;
  logic              at_count;
  logic              at_pos;
  logic              at_new_last;
  logic              last_step;
  ktsr_pkg::key_t    rd_key_fin;
  ktsr_pkg::key_t    cand_fin;
  logic [XW-1:0]     step_x;
  logic [XW-1:0]     count_x;

  ktsr_pkg::status_t rsp_status_next;
  ktsr_pkg::pos_t    rsp_pos_next;
  ktsr_pkg::key_t    rsp_key_next;
  ktsr_pkg::key_t    last_key_next;

  // Per-step compare at the head cell
  always_comb begin
    step_x      = XW'(step);
    count_x     = XW'(count);
    in_range    = step_x < count_x;
    first       = in_range && (head_key == op_key) && !found;
    found_fin   = found || first;
    at_fin      = first ? step : at;
    has_room    = count_x < XW'(DEPTH);
    at_count    = step_x == count_x;
    at_pos      = PW'(step) == PW'(op_pos);
    at_new_last = (step_x + XW'(2)) == count_x;
    last_step   = step == IW'(DEPTH - 1);
    rd_key_fin  = at_pos ? head_key : rd_key;
  end

  // Tail splice: appended key, or last key moved into the removed slot
  always_comb begin
    ring.shift    = (state == S_SCAN);
    ring.tail_key = head_key;
    unique case (op_func)
      ktsr_pkg::FN_ADD: begin
        if (at_count && has_room) begin
          ring.tail_key = op_key;
        end
      end
      ktsr_pkg::FN_ADD_UQ: begin
        if (at_count && has_room && !found) begin
          ring.tail_key = op_key;
        end
      end
      ktsr_pkg::FN_REMOVE: begin
        if (first) begin
          ring.tail_key = last_key;
        end
      end
      default: begin
      end
    endcase
    cand_fin = at_new_last ? ring.tail_key : last_cand;
  end

  // Response payload and last-key tracking at the end of the scan
  always_comb begin
    rsp_status_next = ktsr_pkg::ST_OK;
    rsp_pos_next    = '0;
    rsp_key_next    = '0;
    last_key_next   = last_key;
    unique case (op_func)
      ktsr_pkg::FN_ADD: begin
        if (has_room) begin
          rsp_pos_next  = ktsr_pkg::POS_W'(count);
          last_key_next = op_key;
        end else begin
          rsp_status_next = ktsr_pkg::ST_FULL;
        end
      end
      ktsr_pkg::FN_ADD_UQ: begin
        if (found_fin) begin
          rsp_pos_next = ktsr_pkg::POS_W'(at_fin);
        end else if (has_room) begin
          rsp_pos_next  = ktsr_pkg::POS_W'(count);
          last_key_next = op_key;
        end else begin
          rsp_status_next = ktsr_pkg::ST_FULL;
        end
      end
      ktsr_pkg::FN_FIND: begin
        if (found_fin) rsp_pos_next    = ktsr_pkg::POS_W'(at_fin);
        else           rsp_status_next = ktsr_pkg::ST_NOT_FOUND;
      end
      ktsr_pkg::FN_REMOVE: begin
        if (found_fin) begin
          rsp_pos_next  = ktsr_pkg::POS_W'(at_fin);
          last_key_next = cand_fin;
        end else begin
          rsp_status_next = ktsr_pkg::ST_NOT_FOUND;
        end
      end
      ktsr_pkg::FN_READ: begin
        if (PW'(op_pos) < PW'(count)) begin
          rsp_pos_next = op_pos;
          rsp_key_next = rd_key_fin;
        end else begin
          rsp_status_next = ktsr_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      found <= 1'b0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN;
            step  <= '0;
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          found <= found_fin;
          step  <= step + IW'(1);
          if (last_step) begin
            state <= S_DONE;
            unique case (op_func)
              ktsr_pkg::FN_ADD: begin
                if (has_room) count <= count + CW'(1);
              end
              ktsr_pkg::FN_ADD_UQ: begin
                if (!found_fin && has_room) count <= count + CW'(1);
              end
              ktsr_pkg::FN_REMOVE: begin
                if (found_fin) count <= count - CW'(1);
              end
              ktsr_pkg::FN_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_DONE: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operation, scan captures and response payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_func <= req.func;
      op_key  <= req.key;
      op_pos  <= req.position;
    end
    if (state == S_SCAN) begin
      at        <= at_fin;
      rd_key    <= rd_key_fin;
      last_cand <= cand_fin;
      if (last_step) begin
        rsp.status         <= rsp_status_next;
        rsp.found_position <= rsp_pos_next;
        rsp.read_key       <= rsp_key_next;
        last_key           <= last_key_next;
      end
    end
  end

  // Entry total follows the count register
  assign rsp.entry_total = ktsr_pkg::TOTAL_W'(count);

endmodule

>>> design/key_table_swap_remove_core.sv
// ----------------------------------------------------------------------------
// key_table_swap_remove_core
// Unordered key table kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
// The keys sit in a ring of DEPTH cells that rotates by one cell per clock
// while a scan runs. Every operation turns the ring through one full
// revolution, so each entry passes the head cell in position order and the
// ring ends where it began. Search, append, the swap on remove and read by
// position all happen as the entries pass the head and re-enter at the tail.
// The result is registered at the end of the revolution, and one operation
// runs at a time: a new request is not taken until the result is accepted.
// The request channel is ready only while no operation is open.
module key_table_swap_remove_core #(
  parameter int DEPTH = ktsr_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ktsr_req_if.sink   req,
  ktsr_rsp_if.source rsp
);

  ktsr_pkg::key_t      cell_key [DEPTH];
  ktsr_pkg::ring_ctl_t ring;

  // Sequencer
  ktsr_seq #(.DEPTH(DEPTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .head_key (cell_key[0]),
    .ring     (ring)
  );

  // Ring of cells: each takes its successor, the tail takes the spliced key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      ktsr_cell u_cell (
        .clk       (clk),
        .shift     (ring.shift),
        .from_next (ring.tail_key),
        .key       (cell_key[i])
      );
    end else begin : g_body
      ktsr_cell u_cell (
        .clk       (clk),
        .shift     (ring.shift),
        .from_next (cell_key[i+1]),
        .key       (cell_key[i])
      );
    end
  end

endmodule

>>> design/ktsr_check.sv
// ----------------------------------------------------------------------------
// ktsr_check
// Port-level checks on the key table, bound to the top level.
// ----------------------------------------------------------------------------
module ktsr_check #(
  parameter int DEPTH = ktsr_pkg::DEPTH_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input ktsr_pkg::status_t rsp_status,
  input ktsr_pkg::pos_t    rsp_found_position,
  input ktsr_pkg::key_t    rsp_read_key,
  input ktsr_pkg::total_t  rsp_entry_total
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_key)
      && $stable(rsp_status) && $stable(rsp_found_position))
    else $error("stalled response changed");

  // One operation at a time: no request taken while a result is pending
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request ready while result pending");

  // A request transfer leads to a result only after the scan
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("result appeared right after request");

  // Count never exceeds the table depth
  a_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 127) || (int'(rsp_entry_total) <= DEPTH))
    else $error("entry total above depth");

  // Key data only on a successful read; out of range reports nothing
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ktsr_pkg::ST_OK |->
      rsp_read_key == '0 && rsp_found_position == '0)
    else $error("payload on failed operation");

endmodule

bind key_table_swap_remove_core ktsr_check #(.DEPTH(DEPTH)) u_ktsr_check (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found_position (rsp.found_position),
  .rsp_read_key       (rsp.read_key),
  .rsp_entry_total    (rsp.entry_total)
);
